// ===== sv/zcd_pkg.sv =====
package zcd_pkg;

	// Configuration port
	localparam int CFG_W = 9;
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_WIDTH_X = 2'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT_Y = 2'd1;
	localparam logic [CFG_AW-1:0] REG_DEPTH_Z = 2'd2;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	// Default volume limits
	localparam int DEF_MAX_X = 256;
	localparam int DEF_MAX_Y = 256;
	localparam int DEF_MAX_Z = 256;

	// Cycles of settling after reset or a register write
	localparam int BUSY_W = 3;
	localparam logic [BUSY_W-1:0] BUSY_CYCLES = 3'd4;

	// Stored voxel entry: sign bit above domain bit
	localparam int ENTRY_W = 2;
	localparam int ENTRY_SIGN = 1;
	localparam int ENTRY_DOM = 0;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        in_domain;
		logic        drain;
	} voxel_t;

	typedef struct packed {
		logic crossing;
		logic last_voxel;
	} result_t;

	// Which neighbours of the centre voxel lie inside the volume
	typedef struct packed {
		logic x_lo;
		logic x_hi;
		logic y_lo;
		logic y_hi;
		logic z_lo;
		logic z_hi;
	} bounds_t;

	// A register value of zero counts as one; values above the limit count as the limit.
	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		int unsigned r;
		if (v == '0) begin
			r = 1;
		end else if (32'(v) > maxv) begin
			r = maxv;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

// ===== sv/zcd_delay.sv =====
module zcd_delay import zcd_pkg::*; #(
	parameter int DEPTH = DEF_MAX_X,
	localparam int LW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               restart,
	input  logic [LW-1:0]      len,
	input  logic [ENTRY_W-1:0] d,
	output logic [ENTRY_W-1:0] q
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [AW-1:0]      wp_q;
	logic [AW-1:0]      rp_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] d_q;
	logic               wrap_w;
	logic               wrap_r;
	logic               len_one;

	assign len_one = (len == LW'(1));
	assign wrap_w = (LW'(wp_q) == len - LW'(1));
	assign wrap_r = (LW'(rp_q) == len - LW'(1));

	// The read pointer runs one entry ahead of the write pointer, so the
	// registered read data is the entry needed at the next push.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (restart) begin
			wp_q <= '0;
			rp_q <= len_one ? '0 : AW'(1);
		end else if (push) begin
			wp_q <= wrap_w ? '0 : wp_q + AW'(1);
			rp_q <= wrap_r ? '0 : rp_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= d;
			rd_q <= mem[rp_q];
			d_q <= d;
		end
	end

	// With a length of one the previous push itself is the delayed entry.
	assign q = len_one ? d_q : rd_q;

endmodule

// ===== sv/zcd_window.sv =====
module zcd_window import zcd_pkg::*; #(
	parameter int MAX_X = DEF_MAX_X,
	parameter int MAX_Y = DEF_MAX_Y,
	localparam int XW = $clog2(MAX_X + 1),
	localparam int PW = $clog2(MAX_X * MAX_Y + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               restart,
	input  logic [ENTRY_W-1:0] entry,
	input  logic [XW-1:0]      nx,
	input  logic [PW-1:0]      plane,
	input  bounds_t            bnd,
	output logic               hit
);

	// str[z][y] is the stream delayed by z planes and y rows.
	logic [ENTRY_W-1:0] str  [3][3];
	logic [ENTRY_W-1:0] w0_q [3][3];
	logic [ENTRY_W-1:0] w1_q [3][3];

	for (genvar zi = 0; zi < 3; zi++) begin : g_plane
		if (zi == 0) begin : g_head
			assign str[0][0] = entry;
		end else begin : g_pd
			zcd_delay #(
				.DEPTH(MAX_X * MAX_Y)
			) u_plane (
				.clk    (clk),
				.arst_n (arst_n),
				.push   (push),
				.restart(restart),
				.len    (plane),
				.d      (str[zi-1][0]),
				.q      (str[zi][0])
			);
		end
		for (genvar yi = 1; yi < 3; yi++) begin : g_row
			zcd_delay #(
				.DEPTH(MAX_X)
			) u_row (
				.clk    (clk),
				.arst_n (arst_n),
				.push   (push),
				.restart(restart),
				.len    (nx),
				.d      (str[zi][yi-1]),
				.q      (str[zi][yi])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int z = 0; z < 3; z++) begin
				for (int y = 0; y < 3; y++) begin
					w0_q[z][y] <= str[z][y];
					w1_q[z][y] <= w0_q[z][y];
				end
			end
		end
	end

	// The flag is taken from the window as it stands after the current push:
	// column 0 is the incoming stream, columns 1 and 2 the two registers.
	// Index 0 on an axis is the neighbour at +1, index 2 the one at -1.
	always_comb begin
		logic [ENTRY_W-1:0] me;
		logic [ENTRY_W-1:0] nb;
		logic               ok_x;
		logic               ok_y;
		logic               ok_z;
		logic               any;
		me = w0_q[1][1];
		any = 1'b0;
		for (int z = 0; z < 3; z++) begin
			for (int y = 0; y < 3; y++) begin
				for (int x = 0; x < 3; x++) begin
					nb = (x == 0) ? str[z][y] : ((x == 1) ? w0_q[z][y] : w1_q[z][y]);
					ok_x = (x == 0) ? bnd.x_hi : ((x == 2) ? bnd.x_lo : 1'b1);
					ok_y = (y == 0) ? bnd.y_hi : ((y == 2) ? bnd.y_lo : 1'b1);
					ok_z = (z == 0) ? bnd.z_hi : ((z == 2) ? bnd.z_lo : 1'b1);
					if (!(x == 1 && y == 1 && z == 1) && ok_x && ok_y && ok_z &&
							nb[ENTRY_DOM] && (nb[ENTRY_SIGN] != me[ENTRY_SIGN])) begin
						any = 1'b1;
					end
				end
			end
		end
		hit = me[ENTRY_DOM] & any;
	end

endmodule

// ===== sv/masked_zero_crossing_3d_core.sv =====
// Masked 3D zero-crossing detector.
// Voxels enter on the voxel channel (voxel_valid / voxel_stall) in raster order,
// x fastest, then y, then z. Each transaction carries the float bits, of which
// only the sign is used, the domain bit and a drain bit. Results leave on the
// result channel (result_valid / result_stall), one per voxel, in voxel order.
// A voxel's result appears once the voxel one plane, one row and one voxel
// beyond it has been taken, or once drain transactions follow the volume.
// The result of the transaction that releases it passes through the push
// stage and then the output register. Throughput is one voxel per clock
// while the result channel does not stall, set by one push per cycle through
// the line stores: two plane stores of MAX_X*MAX_Y entries and six row stores
// of MAX_X entries. When the volume is smaller than one plane plus one row
// plus one voxel, the transaction that completes it holds the input while the
// window is flushed.
// The sizes are written through cfg_we / cfg_index / cfg_data while idle; a
// write restarts the volume. After reset and after each write the input is
// stalled while the derived sizes settle.
// A stalled result is held in the output register; the input keeps being
// taken until the one-entry stage in front of it also holds a result.
module masked_zero_crossing_3d_core import zcd_pkg::*; #(
	parameter int MAX_X = DEF_MAX_X,
	parameter int MAX_Y = DEF_MAX_Y,
	parameter int MAX_Z = DEF_MAX_Z
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              voxel_valid,
	output logic              voxel_stall,
	input  voxel_t            voxel,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	localparam int XW = $clog2(MAX_X + 1);
	localparam int YW = $clog2(MAX_Y + 1);
	localparam int ZW = $clog2(MAX_Z + 1);
	localparam int XCW = $clog2(MAX_X);
	localparam int YCW = $clog2(MAX_Y);
	localparam int ZCW = $clog2(MAX_Z);
	localparam longint PLANE_MAX = longint'(MAX_X) * longint'(MAX_Y);
	localparam int PW = $clog2(PLANE_MAX + 1);
	localparam int TW = $clog2(PLANE_MAX * longint'(MAX_Z) + 1);
	localparam int NW = $clog2(PLANE_MAX + longint'(MAX_X) + 3);

	// Configuration and derived sizes
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CFG_W-1:0]  depth_q;
	logic [BUSY_W-1:0] busy_q;
	logic              cfg_hit;
	logic [XW-1:0]     nx_q;
	logic [YW-1:0]     ny_q;
	logic [ZW-1:0]     nz_q;
	logic [XCW-1:0]    nxm1_q;
	logic [YCW-1:0]    nym1_q;
	logic [ZCW-1:0]    nzm1_q;
	logic [PW-1:0]     plane_q;
	logic [TW-1:0]     total_q;
	logic [TW-1:0]     totalm1_q;
	logic [NW-1:0]     lagp1_q;
	logic [XW+YW-1:0]  plane_full;
	logic [PW+ZW-1:0]  total_full;
	logic              busy;

	// Stream bookkeeping
	logic [TW-1:0]  ipos_q;
	logic [TW-1:0]  rg_q;
	logic [NW-1:0]  need_q;
	logic [XCW-1:0] cx_q;
	logic [YCW-1:0] cy_q;
	logic [ZCW-1:0] cz_q;
	logic           acc;
	logic           complete;
	logic           wr;
	logic           ignored;
	logic           emit;
	logic           last;
	logic           load_s1;
	bounds_t        bnd_d;

	// Push stage
	logic               valid_s1;
	logic [NW-1:0]      cnt_s1;
	logic [ENTRY_W-1:0] data_s1;
	logic               emit_s1;
	logic               last_s1;
	bounds_t            bnd_s1;
	logic               final_s1;
	logic               go_s1;
	logic               done_s1;
	logic               out_free;
	logic               hit;
	logic               win_restart;

	// Output register
	logic    result_valid_q;
	result_t result_q;

	assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH_X || cfg_index == REG_HEIGHT_Y ||
			cfg_index == REG_DEPTH_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_RESET;
			height_q <= CFG_RESET;
			depth_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_X: begin
					width_q <= cfg_data;
				end
				REG_HEIGHT_Y: begin
					height_q <= cfg_data;
				end
				REG_DEPTH_Z: begin
					depth_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= BUSY_CYCLES;
		end else if (cfg_hit) begin
			busy_q <= BUSY_CYCLES;
		end else if (busy_q != '0) begin
			busy_q <= busy_q - BUSY_W'(1);
		end
	end

	assign busy = (busy_q != '0);

	assign plane_full = (XW + YW)'(nx_q) * (XW + YW)'(ny_q);
	assign total_full = (PW + ZW)'(plane_q) * (PW + ZW)'(nz_q);

	// Three register levels; the busy window covers their settling.
	always_ff @(posedge clk) begin
		nx_q <= XW'(clamp_dim(width_q, MAX_X));
		ny_q <= YW'(clamp_dim(height_q, MAX_Y));
		nz_q <= ZW'(clamp_dim(depth_q, MAX_Z));
		nxm1_q <= XCW'(nx_q - XW'(1));
		nym1_q <= YCW'(ny_q - YW'(1));
		nzm1_q <= ZCW'(nz_q - ZW'(1));
		plane_q <= PW'(plane_full);
		total_q <= TW'(total_full);
		totalm1_q <= TW'(total_full - (PW + ZW)'(1));
		lagp1_q <= NW'(plane_q) + NW'(nx_q) + NW'(2);
	end

	// need_q counts the pushes still due before the next result's window is
	// complete. A drain before the volume is complete is taken and dropped;
	// once it is complete every transaction counts as a drain.
	assign acc = voxel_valid && !voxel_stall;
	assign complete = (ipos_q == total_q);
	assign wr = !voxel.drain && !complete;
	assign ignored = voxel.drain && !complete;
	assign emit = complete || (wr && (need_q == NW'(1) || ipos_q == totalm1_q));
	assign last = emit && (rg_q == totalm1_q);
	assign load_s1 = acc && !ignored;

	assign bnd_d.x_lo = (cx_q != '0);
	assign bnd_d.x_hi = (cx_q != nxm1_q);
	assign bnd_d.y_lo = (cy_q != '0);
	assign bnd_d.y_hi = (cy_q != nym1_q);
	assign bnd_d.z_lo = (cz_q != '0);
	assign bnd_d.z_hi = (cz_q != nzm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipos_q <= '0;
			rg_q <= '0;
			need_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else if (busy) begin
			ipos_q <= '0;
			rg_q <= '0;
			need_q <= lagp1_q;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else if (load_s1) begin
			if (last) begin
				ipos_q <= '0;
				rg_q <= '0;
				need_q <= lagp1_q;
				cx_q <= '0;
				cy_q <= '0;
				cz_q <= '0;
			end else begin
				if (wr) begin
					ipos_q <= ipos_q + TW'(1);
				end
				if (emit) begin
					rg_q <= rg_q + TW'(1);
					need_q <= NW'(1);
					if (cx_q == nxm1_q) begin
						cx_q <= '0;
						if (cy_q == nym1_q) begin
							cy_q <= '0;
							cz_q <= cz_q + ZCW'(1);
						end else begin
							cy_q <= cy_q + YCW'(1);
						end
					end else begin
						cx_q <= cx_q + XCW'(1);
					end
				end else begin
					need_q <= need_q - NW'(1);
				end
			end
		end
	end

	// The push stage makes one window push per cycle unless the output stalls;
	// a transaction's last push takes its result, if any, to the output register.
	assign out_free = !result_valid_q || !result_stall;
	assign final_s1 = (cnt_s1 == NW'(1));
	assign go_s1 = valid_s1 && (!final_s1 || !emit_s1 || out_free);
	assign done_s1 = go_s1 && final_s1;
	assign voxel_stall = busy || (valid_s1 && !done_s1);
	assign win_restart = busy || (done_s1 && last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cnt_s1 <= emit ? need_q : NW'(1);
			data_s1 <= wr ? {voxel.value_bits[31], voxel.in_domain} : '0;
			emit_s1 <= emit;
			last_s1 <= last;
			bnd_s1 <= bnd_d;
		end else if (go_s1 && !final_s1) begin
			cnt_s1 <= cnt_s1 - NW'(1);
			data_s1 <= '0;
		end
	end

	zcd_window #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go_s1),
		.restart(win_restart),
		.entry  (data_s1),
		.nx     (nx_q),
		.plane  (plane_q),
		.bnd    (bnd_s1),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done_s1 && emit_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && emit_s1) begin
			result_q.crossing <= hit;
			result_q.last_voxel <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== dv/tb_masked_zero_crossing_3d_core.sv =====
module tb_masked_zero_crossing_3d_core;
	timeunit 1ns;
	timeprecision 1ps;
	import zcd_pkg::*;

	localparam int unsigned MAX_X = DEF_MAX_X;
	localparam int unsigned MAX_Y = DEF_MAX_Y;
	localparam int unsigned MAX_Z = DEF_MAX_Z;
	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_AW-1:0] REG_NONE = 2'd3;
	localparam int unsigned MAP_DEPTH = 4096;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic        voxel_valid;
	logic        voxel_stall;
	voxel_t      voxel;
	logic        result_valid;
	logic        result_stall;
	result_t     result;

	masked_zero_crossing_3d_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.voxel_valid  (voxel_valid),
		.voxel_stall  (voxel_stall),
		.voxel        (voxel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Predictor state: register copies, sign/domain map of the current volume,
	// stream positions and the coordinates of the next voxel to be flagged.
	logic [CFG_W-1:0]   size_x;
	logic [CFG_W-1:0]   size_y;
	logic [CFG_W-1:0]   size_z;
	logic [ENTRY_W-1:0] vol_map [MAP_DEPTH];
	int unsigned        vox_taken;
	int unsigned        flags_given;
	int unsigned        ctr_x;
	int unsigned        ctr_y;
	int unsigned        ctr_z;
	result_t            flags_pending [$];

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned tx_calm_left = 0;
	int unsigned rx_hold_req = 0;
	bit          tx_no_gaps = 1'b0;

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] r, input int unsigned lim);
		if (r == '0)
			return 1;
		if (int'(r) > lim)
			return lim;
		return int'(r);
	endfunction

	function automatic int unsigned volume_total();
		return eff_dim(size_x, MAX_X) * eff_dim(size_y, MAX_Y) * eff_dim(size_z, MAX_Z);
	endfunction

	function automatic void model_restart();
		vox_taken = 0;
		flags_given = 0;
		ctr_x = 0;
		ctr_y = 0;
		ctr_z = 0;
	endfunction

	// Stored entries of one volume are kept at their raster position, which
	// matches the circular window as long as only the current volume is read.
	function automatic logic sign_change_around(input int unsigned nx, input int unsigned ny,
			input int unsigned nz);
		logic [ENTRY_W-1:0] self;
		logic [ENTRY_W-1:0] nb;
		int x;
		int y;
		int z;
		logic hit;
		self = vol_map[flags_given];
		hit = 1'b0;
		if (self[ENTRY_DOM]) begin
			for (int dz = -1; dz <= 1; dz++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						x = int'(ctr_x) + dx;
						y = int'(ctr_y) + dy;
						z = int'(ctr_z) + dz;
						if (x >= 0 && x < int'(nx) && y >= 0 && y < int'(ny) &&
								z >= 0 && z < int'(nz) && !(dx == 0 && dy == 0 && dz == 0)) begin
							nb = vol_map[(z * int'(ny) + y) * int'(nx) + x];
							if (nb[ENTRY_DOM] && nb[ENTRY_SIGN] != self[ENTRY_SIGN])
								hit = 1'b1;
						end
					end
				end
			end
		end
		return hit;
	endfunction

	task automatic predict_voxel(input voxel_t v);
		int unsigned nx;
		int unsigned ny;
		int unsigned nz;
		int unsigned plane;
		int unsigned total;
		int unsigned lag;
		result_t flag;
		nx = eff_dim(size_x, MAX_X);
		ny = eff_dim(size_y, MAX_Y);
		nz = eff_dim(size_z, MAX_Z);
		plane = nx * ny;
		total = plane * nz;
		lag = plane + nx + 1;
		if (!v.drain && vox_taken < total) begin
			vol_map[vox_taken][ENTRY_SIGN] = v.value_bits[31];
			vol_map[vox_taken][ENTRY_DOM] = v.in_domain;
			vox_taken++;
		end
		if (vox_taken - flags_given > lag || (vox_taken == total && flags_given < total)) begin
			flag.crossing = sign_change_around(nx, ny, nz);
			flag.last_voxel = (flags_given + 1 == total);
			flags_pending.push_back(flag);
			if (flag.last_voxel) begin
				model_restart();
			end else begin
				flags_given++;
				ctr_x++;
				if (ctr_x >= nx) begin
					ctr_x = 0;
					ctr_y++;
					if (ctr_y >= ny) begin
						ctr_y = 0;
						ctr_z++;
					end
				end
			end
		end
	endtask

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned pick_idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned next_tx_gap();
		int unsigned r;
		if (tx_no_gaps)
			return 0;
		if (tx_calm_left != 0) begin
			tx_calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			tx_calm_left = $urandom_range(30, 150);
			return 0;
		end
		if (r < 55)
			return 0;
		return pick_idle_len();
	endfunction

	function automatic voxel_t random_voxel(input int unsigned neg_pct,
			input int unsigned dom_pct);
		voxel_t v;
		logic neg;
		neg = ($urandom_range(0, 99) < neg_pct);
		case ($urandom_range(0, 9))
			0: v.value_bits = {neg, 31'h0};
			1: v.value_bits = {neg, 31'h7FC00000};
			2: v.value_bits = {neg, 31'h7F800000};
			default: v.value_bits = {neg, 31'($urandom)};
		endcase
		v.in_domain = ($urandom_range(0, 99) < dom_pct);
		v.drain = 1'b0;
		return v;
	endfunction

	// Valid is left high after acceptance so that back-to-back transactions
	// need no bubble; send_voxel lowers it before a gap, settle_idle before a pause.
	task automatic send_voxel(input voxel_t v);
		int unsigned gap;
		gap = next_tx_gap();
		@(negedge clk);
		if (gap != 0) begin
			voxel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		voxel_valid <= 1'b1;
		voxel <= v;
		@(posedge clk);
		while (voxel_stall)
			@(posedge clk);
		items_sent++;
		predict_voxel(v);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		voxel_valid <= 1'b0;
		while (flags_pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH_X: size_x = val;
			REG_HEIGHT_Y: size_y = val;
			REG_DEPTH_Z: size_z = val;
			default: return;
		endcase
		model_restart();
	endtask

	task automatic configure(input logic [CFG_W-1:0] wx, input logic [CFG_W-1:0] hy,
			input logic [CFG_W-1:0] dz);
		settle_idle();
		write_reg(REG_WIDTH_X, wx);
		write_reg(REG_HEIGHT_Y, hy);
		write_reg(REG_DEPTH_Z, dz);
	endtask

	task automatic send_volume(input int unsigned count, input int unsigned neg_pct,
			input int unsigned dom_pct, input bit noisy);
		voxel_t v;
		for (int unsigned i = 0; i < count; i++) begin
			// A drain inside the volume must be ignored by the block.
			if (noisy && $urandom_range(0, 24) == 0) begin
				v = random_voxel(neg_pct, dom_pct);
				v.drain = 1'b1;
				send_voxel(v);
			end
			send_voxel(random_voxel(neg_pct, dom_pct));
		end
	endtask

	// Once the volume is complete, plain voxels also act as drain transactions.
	task automatic flush_volume();
		voxel_t v;
		while (vox_taken == volume_total()) begin
			v = random_voxel(50, 50);
			v.drain = ($urandom_range(0, 3) != 0);
			send_voxel(v);
		end
	endtask

	task automatic test_reset_defaults();
		voxel_t v;
		send_volume(6, 50, 100, 1'b0);
		v = random_voxel(0, 0);
		v.drain = 1'b1;
		send_voxel(v);
	endtask

	task automatic test_tiny_volumes();
		voxel_t v;
		configure('0, '0, '0);
		v = random_voxel(100, 100);
		v.drain = 1'b1;
		send_voxel(v);
		send_voxel(random_voxel(0, 100));
		send_voxel(random_voxel(100, 0));
	endtask

	task automatic test_sign_cases();
		logic [31:0] vals [12] = '{32'h00000000, 32'h80000000, 32'h7FC00000, 32'hFFFFFFFF,
			32'h7FFFFFFF, 32'hFFC00000, 32'h3F800000, 32'hBF800000,
			32'h00000001, 32'h80000001, 32'h7F800000, 32'hFF800000};
		logic [11:0] doms = 12'b1111_0011_0111;
		voxel_t v;
		configure(9'd3, 9'd2, 9'd2);
		for (int i = 0; i < 12; i++) begin
			if (i == 5) begin
				v = '{value_bits: 32'hFFFFFFFF, in_domain: 1'b1, drain: 1'b1};
				send_voxel(v);
			end
			v = '{value_bits: vals[i], in_domain: doms[i], drain: 1'b0};
			send_voxel(v);
		end
		flush_volume();
	endtask

	task automatic test_write_restarts();
		configure(9'd2, 9'd2, 9'd2);
		send_volume(5, 50, 80, 1'b0);
		settle_idle();
		write_reg(REG_DEPTH_Z, 9'd2);
		send_volume(2, 50, 80, 1'b0);
		settle_idle();
		write_reg(REG_NONE, 9'h1FF);
		send_volume(6, 50, 80, 1'b0);
		flush_volume();
	endtask

	task automatic test_random_volumes();
		int unsigned start;
		int unsigned nvol;
		int unsigned neg_pct;
		int unsigned dom_pct;
		logic [CFG_W-1:0] wx;
		logic [CFG_W-1:0] hy;
		logic [CFG_W-1:0] dz;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			wx = ($urandom_range(0, 11) == 0) ? '0 : CFG_W'($urandom_range(1, 8));
			hy = ($urandom_range(0, 11) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
			dz = ($urandom_range(0, 11) == 0) ? '0 : CFG_W'($urandom_range(1, 4));
			configure(wx, hy, dz);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, CFG_W'($urandom));
			case ($urandom_range(0, 4))
				0: neg_pct = 0;
				1: neg_pct = 10;
				2: neg_pct = 50;
				3: neg_pct = 90;
				default: neg_pct = 100;
			endcase
			dom_pct = ($urandom_range(0, 2) == 0) ? 30 : (($urandom_range(0, 1) == 0) ? 80 : 100);
			nvol = $urandom_range(1, 3);
			for (int unsigned k = 0; k < nvol; k++) begin
				// Now and then a volume is cut short; the next register write restarts it.
				if ($urandom_range(0, 9) == 0) begin
					send_volume($urandom_range(0, volume_total() - 1), neg_pct, dom_pct, 1'b1);
					break;
				end
				send_volume(volume_total(), neg_pct, dom_pct, 1'b1);
				flush_volume();
			end
		end
	endtask

	// The receiver holds off while the sender keeps offering, so the result
	// path fills up and the block has to stall its input.
	task automatic test_backpressure();
		configure(9'd5, 9'd3, 9'd3);
		tx_no_gaps = 1'b1;
		rx_hold_req = 300;
		repeat (3) begin
			send_volume(volume_total(), 50, 80, 1'b0);
			flush_volume();
		end
		tx_no_gaps = 1'b0;
	endtask

	task automatic test_size_extremes();
		configure(9'd511, 9'd0, 9'd1);
		send_volume(volume_total(), 50, 80, 1'b0);
		flush_volume();
		configure(9'd1, 9'd1, 9'd300);
		send_volume(volume_total(), 50, 80, 1'b0);
		flush_volume();
	endtask

	initial begin : rx_side
		int unsigned calm_left;
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned r;
		result_stall = 1'b0;
		calm_left = 100;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (calm_left != 0) begin
				calm_left--;
				result_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				r = $urandom_range(0, 99);
				if (r < 4)
					calm_left = $urandom_range(50, 250);
				else if (r < 30)
					stall_left = pick_idle_len();
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (flags_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: none expected, got crossing=%0b last_voxel=%0b",
						results_seen, result.crossing, result.last_voxel);
			end else begin
				want = flags_pending.pop_front();
				if (result.crossing !== want.crossing || result.last_voxel !== want.last_voxel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected crossing=%0b last_voxel=%0b, got %0b %0b",
							results_seen, want.crossing, want.last_voxel,
							result.crossing, result.last_voxel);
				end
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (voxel_valid && !voxel_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("masked_zero_crossing_3d_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		voxel_valid = 1'b0;
		voxel = '0;
		size_x = CFG_RESET;
		size_y = CFG_RESET;
		size_z = CFG_RESET;
		model_restart();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_tiny_volumes();
		test_sign_cases();
		test_write_restarts();
		test_random_volumes();
		test_backpressure();
		test_size_extremes();
		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && flags_pending.size() == 0)
			$display("masked_zero_crossing_3d_core verification clean");
		else
			$display("masked_zero_crossing_3d_core verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/zcd_pkg.sv
sv/zcd_delay.sv
sv/zcd_window.sv
sv/masked_zero_crossing_3d_core.sv
dv/tb_masked_zero_crossing_3d_core.sv
